// ===== sv/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants for the power rail sequencer.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int RAIL_COUNT = 6;
  localparam int RAIL_W     = 3;
  localparam int WAIT_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;
  localparam int EN_W       = 6;
  localparam int SHADOW_X_W = (RAIL_COUNT > EN_W) ? RAIL_COUNT : EN_W;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_ON     = 3'd1,
    ACT_OFF    = 3'd2,
    ACT_SLEEP  = 3'd3,
    ACT_WAKE   = 3'd4,
    ACT_SET    = 3'd5,
    ACT_RESULT = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_RISING  = 3'd1,
    MODE_ON      = 3'd2,
    MODE_FALLING = 3'd3,
    MODE_FAULT   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_ON    = 3'd1,
    CMD_OFF   = 3'd2,
    CMD_SLEEP = 3'd3,
    CMD_WAKE  = 3'd4,
    CMD_SET   = 3'd5
  } cmd_t;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_PRE   = 6'b000010,
    PH_ACK   = 6'b000100,
    PH_RETRY = 6'b001000,
    PH_HOLD  = 6'b010000,
    PH_GAP   = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_HW_ERR = 2'd1,
    ST_NO_RAIL = 2'd2,
    ST_BUSY   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEQ_GAP    = 3'd0,
    REG_RETRY_LIM  = 3'd1,
    REG_RETRY_GAP  = 3'd2,
    REG_PRE_ENABLE = 3'd3,
    REG_PHONE_HOLD = 3'd4,
    REG_WAKE_HOLD  = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] SEQ_GAP_RST    = 16'd10;
  localparam logic [3:0]  RETRY_LIM_RST  = 4'd3;
  localparam logic [7:0]  RETRY_GAP_RST  = 8'd10;
  localparam logic [7:0]  PRE_ENABLE_RST = 8'd5;
  localparam logic [15:0] PHONE_HOLD_RST = 16'd10;
  localparam logic [15:0] WAKE_HOLD_RST  = 16'd1000;
  localparam logic [3:0]  ATTEMPT_MAX    = 4'd15;

endpackage

// ===== sv/power_rail_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// power_rail_sequencer_unit
// Sequences power rails up and down, issues rail write requests with retry,
// and frames rail 0 with the phone-on pin.
// ----------------------------------------------------------------------------
// One input item (tick, command or write result) is accepted per clock while
// the output side keeps up; its single result item appears on the output
// register the following cycle. The whole state update for an item, including
// any chain of zero-length waits, resolves in combinational logic between the
// state registers and the output register, so the output register is the only
// register on the path; a stalled output holds one result and accepts the
// next item in the same cycle the result is taken.
module power_rail_sequencer_unit
  import prs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // rail_index[3:0], rail_level[4], write_ok[5], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[2:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // rail_enables[5:0], phone_on[6], mode[9:7], fault_valid[10],
  // fault_rail[13:11], write_req[14], write_rail[17:15], write_level[18],
  // busy_res[19], done_res[20], cmd_status[22:21], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [15:0] seq_gap_r;
  logic [3:0]  retry_lim_r;
  logic [7:0]  retry_gap_r;
  logic [7:0]  pre_enable_r;
  logic [15:0] phone_hold_r;
  logic [15:0] wake_hold_r;

  // sequencer state
  mode_t                 mode_r, mode_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  phase_t                phase_r, phase_nxt;
  logic [RAIL_W-1:0]     rail_r, rail_nxt;
  logic [WAIT_W-1:0]     wait_r, wait_nxt;
  logic [3:0]            attempt_r, attempt_nxt;
  logic                  pend_r, pend_nxt;
  logic [RAIL_COUNT-1:0] shadow_r, shadow_nxt;
  logic                  phone_r, phone_nxt;
  logic                  fault_r, fault_nxt;
  logic [RAIL_W-1:0]     fault_idx_r, fault_idx_nxt;
  logic                  level_r, level_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  in_fire;
  logic                  busy;
  action_t               in_action;
  logic [3:0]            in_rail;
  logic                  in_level;
  logic                  in_ok;
  logic [3:0]            limit;

  // result of this item
  logic                  o_req;
  logic                  o_done;
  status_t               o_status;
  logic [SHADOW_X_W-1:0] shadow_x;

  // follow-on events, resolved in dependency order
  logic                  ev_retry, ev_rail_done, ev_hold, ev_next_on, ev_gap;
  logic                  ev_issue, ev_finish;
  status_t               fin_status;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign busy      = (cmd_r != CMD_NONE);
  assign in_action = action_t'(in_tuser);
  assign in_rail   = in_tdata[3:0];
  assign in_level  = in_tdata[4];
  assign in_ok     = in_tdata[5];
  assign limit     = (retry_lim_r == 4'd0) ? 4'd1 : retry_lim_r;

  always_comb begin
    mode_nxt      = mode_r;
    cmd_nxt       = cmd_r;
    phase_nxt     = phase_r;
    rail_nxt      = rail_r;
    wait_nxt      = wait_r;
    attempt_nxt   = attempt_r;
    pend_nxt      = pend_r;
    shadow_nxt    = shadow_r;
    phone_nxt     = phone_r;
    fault_nxt     = fault_r;
    fault_idx_nxt = fault_idx_r;
    level_nxt     = level_r;
    o_req         = 1'b0;
    o_done        = 1'b0;
    o_status      = ST_OK;
    ev_retry      = 1'b0;
    ev_rail_done  = 1'b0;
    ev_hold       = 1'b0;
    ev_next_on    = 1'b0;
    ev_gap        = 1'b0;
    ev_issue      = 1'b0;
    ev_finish     = 1'b0;
    fin_status    = ST_OK;

    if (in_fire) begin
      unique case (in_action)
        ACT_TICK: begin
          if (busy && phase_r != PH_ACK && phase_r != PH_IDLE && wait_r != '0) begin
            wait_nxt = wait_r - WAIT_W'(1);
            if (wait_r == WAIT_W'(1)) begin
              unique case (phase_r)
                PH_PRE:   ev_issue = 1'b1;
                PH_RETRY: ev_retry = 1'b1;
                PH_HOLD:  ev_hold  = 1'b1;
                PH_GAP:   ev_gap   = 1'b1;
                default:  phase_nxt = PH_IDLE;
              endcase
            end
          end
        end
        ACT_RESULT: begin
          if (pend_r && phase_r == PH_ACK) begin
            pend_nxt = 1'b0;
            if (in_ok) begin
              shadow_nxt[rail_r] = level_r;
              ev_rail_done = 1'b1;
            end else begin
              if (attempt_r < ATTEMPT_MAX) begin
                attempt_nxt = attempt_r + 4'd1;
              end
              if (retry_gap_r == 8'd0) begin
                ev_retry = 1'b1;
              end else begin
                phase_nxt = PH_RETRY;
                wait_nxt  = WAIT_W'(retry_gap_r);
              end
            end
          end
        end
        ACT_ON, ACT_OFF, ACT_SLEEP, ACT_WAKE, ACT_SET: begin
          if (busy) begin
            o_done   = 1'b1;
            o_status = ST_BUSY;
          end else if (in_action == ACT_ON) begin
            if (mode_r == MODE_ON) begin
              o_done = 1'b1;
            end else if (mode_r == MODE_FAULT) begin
              o_done   = 1'b1;
              o_status = ST_HW_ERR;
            end else begin
              cmd_nxt       = CMD_ON;
              mode_nxt      = MODE_RISING;
              fault_nxt     = 1'b0;
              fault_idx_nxt = '0;
              rail_nxt      = '0;
              level_nxt     = 1'b1;
              attempt_nxt   = 4'd0;
              phone_nxt     = 1'b1;
              if (pre_enable_r == 8'd0) begin
                ev_issue = 1'b1;
              end else begin
                phase_nxt = PH_PRE;
                wait_nxt  = WAIT_W'(pre_enable_r);
              end
            end
          end else if (in_action == ACT_OFF || in_action == ACT_SLEEP) begin
            if (mode_r == MODE_OFF) begin
              o_done = 1'b1;
            end else begin
              cmd_nxt     = (in_action == ACT_OFF) ? CMD_OFF : CMD_SLEEP;
              mode_nxt    = MODE_FALLING;
              rail_nxt    = RAIL_W'(RAIL_COUNT - 1);
              level_nxt   = 1'b0;
              attempt_nxt = 4'd0;
              ev_issue    = 1'b1;
            end
          end else if (in_action == ACT_WAKE) begin
            cmd_nxt     = CMD_WAKE;
            rail_nxt    = '0;
            level_nxt   = 1'b1;
            attempt_nxt = 4'd0;
            phone_nxt   = 1'b1;
            if (pre_enable_r == 8'd0) begin
              ev_issue = 1'b1;
            end else begin
              phase_nxt = PH_PRE;
              wait_nxt  = WAIT_W'(pre_enable_r);
            end
          end else begin
            if (in_rail >= 4'(RAIL_COUNT)) begin
              o_done   = 1'b1;
              o_status = ST_NO_RAIL;
            end else begin
              cmd_nxt     = CMD_SET;
              rail_nxt    = RAIL_W'(in_rail);
              level_nxt   = in_level;
              attempt_nxt = 4'd0;
              ev_issue    = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // retry gap over: try again or give up on this rail
    if (ev_retry) begin
      if (attempt_nxt >= limit) begin
        if (cmd_nxt == CMD_ON) begin
          if (rail_nxt == '0) begin
            phone_nxt = 1'b0;
          end
          fault_nxt     = 1'b1;
          fault_idx_nxt = rail_nxt;
          mode_nxt      = MODE_FAULT;
          ev_finish     = 1'b1;
          fin_status    = ST_HW_ERR;
        end else if (cmd_nxt == CMD_SET) begin
          ev_finish  = 1'b1;
          fin_status = ST_HW_ERR;
        end else begin
          ev_rail_done = 1'b1;
        end
      end else begin
        ev_issue = 1'b1;
      end
    end

    if (ev_rail_done) begin
      unique case (cmd_nxt)
        CMD_ON: begin
          if (rail_nxt == '0) begin
            if (phone_hold_r == 16'd0) begin
              ev_hold = 1'b1;
            end else begin
              phase_nxt = PH_HOLD;
              wait_nxt  = phone_hold_r;
            end
          end else begin
            ev_next_on = 1'b1;
          end
        end
        CMD_OFF, CMD_SLEEP: begin
          if (rail_nxt != '0) begin
            if (seq_gap_r == 16'd0) begin
              ev_gap = 1'b1;
            end else begin
              phase_nxt = PH_GAP;
              wait_nxt  = seq_gap_r;
            end
          end else begin
            ev_finish = 1'b1;
          end
        end
        CMD_WAKE: begin
          if (wake_hold_r == 16'd0) begin
            ev_hold = 1'b1;
          end else begin
            phase_nxt = PH_HOLD;
            wait_nxt  = wake_hold_r;
          end
        end
        default: ev_finish = 1'b1;
      endcase
    end

    // phone-on hold over
    if (ev_hold) begin
      phone_nxt = 1'b0;
      if (cmd_nxt == CMD_ON) begin
        ev_next_on = 1'b1;
      end else begin
        ev_finish = 1'b1;
      end
    end

    if (ev_next_on) begin
      if ({1'b0, rail_nxt} + (RAIL_W + 1)'(1) < (RAIL_W + 1)'(RAIL_COUNT)) begin
        if (seq_gap_r == 16'd0) begin
          ev_gap = 1'b1;
        end else begin
          phase_nxt = PH_GAP;
          wait_nxt  = seq_gap_r;
        end
      end else begin
        mode_nxt  = MODE_ON;
        ev_finish = 1'b1;
      end
    end

    // gap between rails over: move to the next rail, or end a sleep that has reached rail 1
    if (ev_gap) begin
      if (cmd_nxt == CMD_ON) begin
        rail_nxt    = rail_nxt + RAIL_W'(1);
        level_nxt   = 1'b1;
        attempt_nxt = 4'd0;
        ev_issue    = 1'b1;
      end else if (cmd_nxt == CMD_SLEEP && rail_nxt == RAIL_W'(1)) begin
        ev_finish = 1'b1;
      end else begin
        rail_nxt    = rail_nxt - RAIL_W'(1);
        level_nxt   = 1'b0;
        attempt_nxt = 4'd0;
        ev_issue    = 1'b1;
      end
    end

    if (ev_issue) begin
      pend_nxt  = 1'b1;
      phase_nxt = PH_ACK;
      o_req     = 1'b1;
    end

    if (ev_finish) begin
      if (cmd_nxt == CMD_OFF || cmd_nxt == CMD_SLEEP) begin
        mode_nxt      = MODE_OFF;
        fault_nxt     = 1'b0;
        fault_idx_nxt = '0;
      end
      cmd_nxt   = CMD_NONE;
      phase_nxt = PH_IDLE;
      wait_nxt  = '0;
      o_done    = 1'b1;
      o_status  = fin_status;
    end
  end

  assign shadow_x = SHADOW_X_W'(shadow_nxt);

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[5:0]   = shadow_x[EN_W-1:0];
    out_data_nxt[6]     = phone_nxt;
    out_data_nxt[9:7]   = mode_nxt;
    out_data_nxt[10]    = fault_nxt;
    out_data_nxt[13:11] = fault_nxt ? fault_idx_nxt : '0;
    out_data_nxt[14]    = o_req;
    out_data_nxt[17:15] = o_req ? rail_nxt : '0;
    out_data_nxt[18]    = o_req & level_nxt;
    out_data_nxt[19]    = (cmd_nxt != CMD_NONE);
    out_data_nxt[20]    = o_done;
    out_data_nxt[22:21] = o_status;
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_gap_r    <= SEQ_GAP_RST;
      retry_lim_r  <= RETRY_LIM_RST;
      retry_gap_r  <= RETRY_GAP_RST;
      pre_enable_r <= PRE_ENABLE_RST;
      phone_hold_r <= PHONE_HOLD_RST;
      wake_hold_r  <= WAKE_HOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SEQ_GAP:    seq_gap_r    <= cfg_wdata;
        REG_RETRY_LIM:  retry_lim_r  <= cfg_wdata[3:0];
        REG_RETRY_GAP:  retry_gap_r  <= cfg_wdata[7:0];
        REG_PRE_ENABLE: pre_enable_r <= cfg_wdata[7:0];
        REG_PHONE_HOLD: phone_hold_r <= cfg_wdata;
        REG_WAKE_HOLD:  wake_hold_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      cmd_r       <= CMD_NONE;
      phase_r     <= PH_IDLE;
      rail_r      <= '0;
      wait_r      <= '0;
      attempt_r   <= 4'd0;
      pend_r      <= 1'b0;
      shadow_r    <= '0;
      phone_r     <= 1'b0;
      fault_r     <= 1'b0;
      fault_idx_r <= '0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      cmd_r       <= cmd_nxt;
      phase_r     <= phase_nxt;
      rail_r      <= rail_nxt;
      wait_r      <= wait_nxt;
      attempt_r   <= attempt_nxt;
      pend_r      <= pend_nxt;
      shadow_r    <= shadow_nxt;
      phone_r     <= phone_nxt;
      fault_r     <= fault_nxt;
      fault_idx_r <= fault_idx_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a sequence is running exactly when the phase is not idle
  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r != CMD_NONE) == (phase_r != PH_IDLE))
    else $error("command and phase disagree");

  // a write is outstanding exactly while waiting for its result
  a_pend_ack: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == (phase_r == PH_ACK))
    else $error("write pending flag out of step with phase");

  // fault mode carries the fault record, which survives only until shutdown ends
  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r ? (mode_r == MODE_FAULT || mode_r == MODE_FALLING) : (mode_r != MODE_FAULT))
    else $error("fault flag and mode disagree");

  // a timed phase never sits with an empty counter
  a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PRE || phase_r == PH_RETRY || phase_r == PH_HOLD ||
     phase_r == PH_GAP) |-> (wait_r != '0))
    else $error("timed phase with zero wait count");

  // a result that finishes a command leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && o_done) |=> (cmd_r == CMD_NONE || $past(busy)))
    else $error("command finished but block still busy");

endmodule
